// ----- rtl/sha256_hash_unit_assert.svh -----
// Assertion macros used by the hash unit controller.
`ifndef SHA256_HASH_UNIT_ASSERT_SVH
`define SHA256_HASH_UNIT_ASSERT_SVH
`ifndef SYNTH
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/sha_pkg.sv -----
// Package with SHA-256 constants, controller types and a helper function.
`default_nettype none
package sha_pkg;
	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};
	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS = 6'd56;

	typedef enum logic [2:0] {
		ST_IDLE, ST_COMP, ST_FOLD, ST_PAD, ST_OUT
	} state_t;

	// Byte source selection for the block buffer.
	typedef enum logic [1:0] {
		SRC_DATA, SRC_PAD, SRC_ZERO, SRC_LEN
	} src_t;

	typedef struct packed {
		logic put;      // write one byte at the current position
		src_t src;
		logic start;    // load working vars from hash state
		logic round;    // run one round
		logic fold;     // add working vars into hash state
		logic latch_len;
		logic count;    // add eight to bit count
		logic clear;    // return to the initial state
		logic shift_out;// rotate hash state by one word
	} cmd_t;

	typedef struct packed {
		logic [5:0] pos;
		logic       rounds_done;
	} stat_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

// ----- rtl/sha_ctrl.sv -----
// Controller state machine for the hash unit.
`default_nettype none
module sha_ctrl (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       word_index,
	output logic             last_word,
	input  wire sha_pkg::stat_t st,
	output sha_pkg::cmd_t    cmd
);
	import sha_pkg::*;
	`include "sha256_hash_unit_assert.svh"

	state_t state_q, state_d;
	logic   fin_q, fin_d;    // message is finishing (padding phase)
	logic   lenph_q, lenph_d;// length bytes in progress
	logic [2:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fin_q <= 1'b0;
			lenph_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			fin_q <= fin_d;
			lenph_q <= lenph_d;
			cnt_q <= cnt_d;
		end
	end

	always_comb begin
		state_d = state_q;
		fin_d = fin_q;
		lenph_d = lenph_q;
		cnt_d = cnt_q;
		cmd = '0;
		cmd.src = SRC_DATA;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (byte_valid) begin
						cmd.put = 1'b1;
						cmd.count = 1'b1;
					end
					if (last) begin
						cmd.latch_len = 1'b1;
						fin_d = 1'b1;
						lenph_d = 1'b0;
					end
					if (byte_valid && st.pos == 6'd63) begin
						state_d = ST_COMP;
						cmd.start = 1'b1;
					end else if (last) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_COMP: begin
				cmd.round = 1'b1;
				if (st.rounds_done) state_d = ST_FOLD;
			end
			ST_FOLD: begin
				cmd.fold = 1'b1;
				if (!fin_q) state_d = ST_IDLE;
				else if (lenph_q && st.pos == 6'd0) begin
					state_d = ST_OUT;
					cnt_d = '0;
				end else state_d = ST_PAD;
			end
			ST_PAD: begin
				// First pad cycle writes the marker byte, then zeros, then length.
				// The length starts only at the length slot of a block that
				// still has room for it; a marker at or past that slot forces zeros
				// to the end of the block and one more block.
				cmd.put = 1'b1;
				if (!lenph_q && cnt_q == 3'd0 && !cmd.start) begin
					cmd.src = SRC_PAD;
					cnt_d = 3'd1;
				end else if (lenph_q || st.pos == LEN_POS) begin
					cmd.src = SRC_LEN;
					lenph_d = 1'b1;
				end else begin
					cmd.src = SRC_ZERO;
				end
				if (st.pos == 6'd63) begin
					state_d = ST_COMP;
					cmd.start = 1'b1;
				end
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					cmd.shift_out = 1'b1;
					cnt_d = cnt_q + 3'd1;
					if (cnt_q == 3'd7) begin
						cmd.clear = 1'b1;
						fin_d = 1'b0;
						lenph_d = 1'b0;
						cnt_d = '0;
						state_d = ST_IDLE;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign word_index = cnt_q;
	assign last_word = (cnt_q == 3'd7);

	`SHA_ASSERT_IMP(a_out_only_fin, clk, arst_n, out_valid, fin_q && lenph_q)
	`SHA_ASSERT_IMP(a_no_accept_busy, clk, arst_n, state_q != ST_IDLE, in_stall)
	`SHA_ASSERT_NXT(a_fold_after, clk, arst_n, state_q == ST_COMP && st.rounds_done,
		state_q == ST_FOLD)
endmodule
`default_nettype wire

// ----- rtl/sha_dpath.sv -----
// Datapath: block buffer, schedule, round logic, hash state and length.
`default_nettype none
module sha_dpath (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire sha_pkg::cmd_t cmd,
	input  wire logic [7:0]  data_byte,
	output sha_pkg::stat_t   st,
	output logic [31:0]      digest_word
);
	import sha_pkg::*;

	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] bits_q, len_q;
	logic [5:0]  pos_q;
	logic [5:0]  rnd_q;

	logic [7:0] b;
	logic [2:0] lsel;
	always_comb begin
		lsel = pos_q[2:0];
		case (cmd.src)
			SRC_DATA: b = data_byte;
			SRC_PAD:  b = PAD_BYTE;
			SRC_ZERO: b = 8'h00;
			SRC_LEN:  b = len_q[8*(7-lsel) +: 8];
			default:  b = 8'h00;
		endcase
	end

	// Schedule: the window shifts by one word each round; w_q[0] is current.
	logic [31:0] s0w, s1w, wnew;
	assign s0w = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1w = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wnew = w_q[0] + s0w + w_q[9] + s1w;

	logic [31:0] e1, ch, t1, a0, maj, t2;
	assign e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
	assign ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign t1 = v_q[7] + e1 + ch + ROUND_K[rnd_q] + w_q[0];
	assign a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
	assign maj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t2 = a0 + maj;

	always_ff @(posedge clk) begin
		if (cmd.put) begin
			w_q[pos_q[5:2]][8*(3-pos_q[1:0]) +: 8] <= b;
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
		if (cmd.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end else if (cmd.round) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (cmd.latch_len) len_q <= bits_q + (cmd.count ? 64'd8 : 64'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
			bits_q <= '0;
			pos_q <= '0;
			rnd_q <= '0;
		end else begin
			if (cmd.put) pos_q <= pos_q + 6'd1;
			if (cmd.count) bits_q <= bits_q + 64'd8;
			if (cmd.start) rnd_q <= '0;
			else if (cmd.round) rnd_q <= rnd_q + 6'd1;
			if (cmd.fold) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
			end else if (cmd.clear) begin
				for (int i = 0; i < 8; i++) h_q[i] <= INIT_H[i];
				bits_q <= '0;
				pos_q <= '0;
			end else if (cmd.shift_out) begin
				for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
				h_q[7] <= h_q[0];
			end
		end
	end

	assign st.pos = pos_q;
	assign st.rounds_done = (rnd_q == 6'd63);
	assign digest_word = h_q[0];
endmodule
`default_nettype wire

// ----- rtl/sha256_hash_unit.sv -----
// Top level of the streaming SHA-256 hash unit.
// Usage: the input channel moves one word per handshake: a message byte on
// data_byte with byte_valid, and last on the final word of a message. A word
// with byte_valid low and last low is a no-op; byte_valid low with last high
// ends the message without a byte, which also hashes the empty message.
// Bytes are taken one per cycle while the 64-byte block buffer fills. When a
// block completes, the round unit runs 64 rounds, one round a cycle, and then
// folds the working variables into the hash state. After last, padding is
// written one byte a cycle into the buffer, pausing while a filled block is
// compressed; one or two padded blocks are compressed, and the digest is
// delivered as eight output words, index 0 first, last_word on index 7.
// The round unit sets the rate; input is stalled in rounds, fold, padding
// and digest delivery. Output stall simply holds the current digest word.
// Reset loads the standard initial hash values and clears the length count;
// after the eighth digest word the unit returns to that state by itself.
`default_nettype none
module sha256_hash_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        byte_valid,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      digest_word,
	output logic [2:0]       word_index,
	output logic             last_word
);
	import sha_pkg::*;

	cmd_t  cmd;
	stat_t st;

	sha_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.byte_valid(byte_valid), .last(last), .out_valid(out_valid),
		.out_stall(out_stall), .word_index(word_index), .last_word(last_word),
		.st(st), .cmd(cmd)
	);

	sha_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .data_byte(data_byte),
		.st(st), .digest_word(digest_word)
	);
endmodule
`default_nettype wire
